// ----- hw/rtl/sorted_priority_queue_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Shared helpers that wrap concurrent assertions with the reset disable.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/spq_pkg.sv -----
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Command and status codes and the types that travel along the cell row.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam logic [1:0] CMD_PUSH      = 2'd0;
  localparam logic [1:0] CMD_POP_FRONT = 2'd1;
  localparam logic [1:0] CMD_POP_BACK  = 2'd2;
  localparam logic [1:0] CMD_REMOVE    = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic        [31:0] val;
    logic signed [31:0] prio;
  } entry_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic   valid;
    logic   placed;  // entry stays ahead of the entry being pushed
    entry_t entry;
  } link_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic   push;
    logic   trim;
    entry_t item;
  } op_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one list position; compares against a pushed entry and moves data
// to or from its neighbors.
// ---------------------------------------------------------------------------
module spq_cell #(
  parameter bit HEAD = 1'b0
) (
  input  logic           clk,
  input  logic           rst,
  input  spq_pkg::op_t   op,
  input  logic           pull,
  input  spq_pkg::link_t left,
  input  spq_pkg::link_t right,
  output spq_pkg::link_t link
);
  import spq_pkg::*;

  logic   valid;
  logic   valid_next;
  entry_t entry;
  entry_t entry_next;
  logic   moves;

  // Head yields only to a strictly smaller priority; later cells also on a tie.
  always_comb begin
    if (HEAD) begin
      moves = entry.prio > op.item.prio;
    end else begin
      moves = entry.prio >= op.item.prio;
    end
  end

  assign link.valid  = valid;
  assign link.placed = valid & ~moves;
  assign link.entry  = entry;

  always_comb begin
    valid_next = valid;
    entry_next = entry;
    if (op.push) begin
      valid_next = valid | left.valid;
      if (!(valid && !moves)) begin
        entry_next = left.placed ? op.item : left.entry;
      end
    end else if (pull) begin
      valid_next = right.valid;
      entry_next = right.entry;
    end else if (op.trim) begin
      // drop the last valid entry
      valid_next = valid & right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- hw/rtl/sorted_priority_queue_unit.sv -----
// ---------------------------------------------------------------------------
// Sorted priority queue unit
// Keeps up to CAPACITY entries sorted by ascending signed priority.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel takes one command per beat: s_tuser carries the
//   command (push, pop front, pop back, remove at index) and s_tdata the
//   value, priority and remove index. Each command yields exactly one beat
//   on the master channel with the status, the entry count and the front
//   entry after the command.
//   The result beat is registered, and a new command is taken in every
//   cycle while s_tready is high: all cells compare and shift in
//   parallel, so a whole insert or removal is done when its result is registered.
//   A single result register sits at the output; s_tready is high while it
//   is empty or being drained, so a stalled receiver holds the result and
//   stops new commands without losing any.
//   Reset empties the list and clears the result valid flag; entry storage
//   itself is not cleared, cells are marked invalid.
//   Error cases (push when full, pop when empty, remove beyond the count)
//   leave the list unchanged and report a nonzero status.
// ---------------------------------------------------------------------------
`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [31:0] item_value, [63:32] item_priority, [71:64] remove_index
  input  logic [71:0] s_tdata,
  // [1:0] command
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [CW+1:2] entry_count, [CW+2] front_valid,
  // [CW+34:CW+3] front_value, [CW+66:CW+35] front_priority, zero fill
  output logic [((67 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata
);
  import spq_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int OUT_W = ((67 + CW + 7) / 8) * 8;
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

  logic [1:0]    cmd;
  logic [7:0]    rm_index;
  logic [7:0]    pull_pos;
  logic          accept;
  logic          full;
  logic          empty;
  logic          index_ok;
  logic          pull_en;
  op_t           op;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [1:0]    status;
  logic [1:0]    status_next;
  link_t         links [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  entry_t        front;
  logic          front_valid;

  localparam link_t HEAD_LINK = '{valid: 1'b1, placed: 1'b1, entry: '0};
  localparam link_t TAIL_LINK = '{valid: 1'b0, placed: 1'b0, entry: '0};

  assign cmd      = s_tuser;
  assign rm_index = s_tdata[71:64];
  assign s_tready = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;

  assign full     = count == CAP_COUNT;
  assign empty    = count == '0;
  assign index_ok = 9'(rm_index) < 9'(count);

  always_comb begin
    op.item.val  = s_tdata[31:0];
    op.item.prio = s_tdata[63:32];
    op.push      = 1'b0;
    op.trim      = 1'b0;
    pull_en      = 1'b0;
    pull_pos     = '0;
    status_next  = ST_DONE;
    case (cmd)
      CMD_PUSH: begin
        op.push     = accept & ~full;
        status_next = full ? ST_FULL : ST_DONE;
      end
      CMD_POP_FRONT: begin
        pull_en     = accept & ~empty;
        status_next = empty ? ST_EMPTY : ST_DONE;
      end
      CMD_POP_BACK: begin
        op.trim     = accept & ~empty;
        status_next = empty ? ST_EMPTY : ST_DONE;
      end
      CMD_REMOVE: begin
        pull_en     = accept & index_ok;
        pull_pos    = rm_index;
        status_next = index_ok ? ST_DONE : ST_EMPTY;
      end
      default: begin
        status_next = ST_EMPTY;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (op.push) begin
      count_next = count + CW'(1);
    end else if (pull_en || op.trim) begin
      count_next = count - CW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic pull_here;
    assign pull_here = pull_en & (pull_pos <= 8'(i));
    spq_cell #(
      .HEAD (i == 0)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .op    (op),
      .pull  (pull_here),
      .left  ((i == 0) ? HEAD_LINK : links[(i == 0) ? 0 : i - 1]),
      .right ((i == CAPACITY - 1) ? TAIL_LINK : links[(i == CAPACITY - 1) ? i : i + 1]),
      .link  (links[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  // Head cell stays frozen while the result waits, so read it directly.
  assign front_valid = links[0].valid;
  assign front       = front_valid ? links[0].entry : '0;

  assign m_tdata = OUT_W'({front.prio, front.val, front_valid, count, status});

  `SPQ_ASSERT_ALWAYS(a_count_matches_cells, $countones(valid_vec) == count,
    "entry count disagrees with valid cells")
  `SPQ_ASSERT_ALWAYS(a_cells_packed, ((valid_vec + 1'b1) & valid_vec) == '0,
    "valid cells are not packed toward the head")
  `SPQ_ASSERT_NEXT(a_push_grows, op.push, count == $past(count) + CW'(1),
    "accepted push did not grow the list")
  `SPQ_ASSERT_NEXT(a_error_holds, accept && status_next != ST_DONE,
    count == $past(count) && status != ST_DONE,
    "failed command changed the list")

endmodule
